// ----- hdl/clbp_pkg.sv -----
// Shared types, character codes, status codes and helpers for the CPU list parser.
package clbp_pkg;

  // Width of the result mask as seen on the port.
  localparam int CPU_MASK_W = 64;
  localparam int SET_COUNT_W = 7;
  localparam int STATUS_W = 2;

  // Longest decimal id accepted, in digits, and the number base.
  localparam int MAX_ID_DIGITS = 4;
  localparam int DEC_BASE = 10;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYNTAX = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // ASCII codes the parser recognises.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [CPU_MASK_W-1:0]  cpu_mask;
    logic [SET_COUNT_W-1:0] set_count;
    logic [STATUS_W-1:0]    status;
  } out_beat_t;

  // Handshake decisions from the top level to the parser core.
  typedef struct packed {
    logic char_take;
    logic end_take;
  } parse_ctl_t;

  // Final mask and status of one text, produced on the end beat.
  typedef struct packed {
    logic [CPU_MASK_W-1:0] mask;
    logic [STATUS_W-1:0]   status;
  } parse_result_t;

  // Bit count as a balanced adder tree, six levels deep.
  function automatic logic [SET_COUNT_W-1:0] popcount64(input logic [CPU_MASK_W-1:0] v);
    logic [1:0] s2[CPU_MASK_W/2];
    logic [2:0] s4[CPU_MASK_W/4];
    logic [3:0] s8[CPU_MASK_W/8];
    logic [4:0] s16[CPU_MASK_W/16];
    logic [5:0] s32[CPU_MASK_W/32];
    for (int i = 0; i < CPU_MASK_W/2; i++) begin
      s2[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
    end
    for (int i = 0; i < CPU_MASK_W/4; i++) begin
      s4[i] = 3'(s2[2*i]) + 3'(s2[2*i+1]);
    end
    for (int i = 0; i < CPU_MASK_W/8; i++) begin
      s8[i] = 4'(s4[2*i]) + 4'(s4[2*i+1]);
    end
    for (int i = 0; i < CPU_MASK_W/16; i++) begin
      s16[i] = 5'(s8[2*i]) + 5'(s8[2*i+1]);
    end
    for (int i = 0; i < CPU_MASK_W/32; i++) begin
      s32[i] = 6'(s16[2*i]) + 6'(s16[2*i+1]);
    end
    return SET_COUNT_W'(s32[0]) + SET_COUNT_W'(s32[1]);
  endfunction

endpackage

// ----- hdl/clbp_parser.sv -----
// Character-at-a-time CPU list parser core: parse state, mask accumulation and final status.
module clbp_parser #(
  parameter int MAX_CPUS = 64,
  parameter int MAX_TEXT_LEN = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  clbp_pkg::parse_ctl_t   ctl,
  input  logic [7:0]             char_byte,
  output clbp_pkg::parse_result_t result
);

  localparam int IDW = $clog2(MAX_CPUS);
  localparam int VW = IDW + 4;
  localparam int LENW = $clog2(MAX_TEXT_LEN + 1);

  typedef enum logic [2:0] {
    PH_START,
    PH_FIRST,
    PH_DASH,
    PH_SECOND,
    PH_AFTER
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [IDW-1:0]                   first_id_r, first_id_nxt;
  logic [IDW-1:0]                   second_id_r, second_id_nxt;
  logic [2:0]                       digit_count_r, digit_count_nxt;
  logic [MAX_CPUS-1:0]              mask_r, mask_nxt;
  logic [clbp_pkg::STATUS_W-1:0]    err_r, err_nxt;
  logic [LENW-1:0]                  len_r, len_nxt;

  logic                             is_blank, is_digit, in_id;
  logic [7:0]                       dig_full;
  logic [IDW-1:0]                   acc_id, range_lo, range_hi;
  logic [2:0]                       acc_cnt, cnt_inc;
  logic [VW-1:0]                    id_val;
  logic                             digit_bad, descending;
  logic [MAX_CPUS-1:0]              range_bits;
  logic [clbp_pkg::STATUS_W-1:0]    end_err, end_status;
  logic [MAX_CPUS-1:0]              end_mask;

  always_comb begin
    is_blank = (char_byte == clbp_pkg::CH_SPACE) || (char_byte == clbp_pkg::CH_TAB);
    is_digit = (char_byte >= clbp_pkg::CH_ZERO) && (char_byte <= clbp_pkg::CH_NINE);
    dig_full = char_byte - clbp_pkg::CH_ZERO;
    in_id = (phase_r == PH_FIRST) || (phase_r == PH_SECOND);

    // A new id starts from zero; a running id continues from its register.
    acc_id = in_id ? ((phase_r == PH_SECOND) ? second_id_r : first_id_r) : '0;
    acc_cnt = in_id ? digit_count_r : 3'd0;
    cnt_inc = acc_cnt + 3'd1;
    id_val = VW'(acc_id) * VW'(clbp_pkg::DEC_BASE) + VW'(dig_full[3:0]);
    digit_bad = (cnt_inc > 3'(clbp_pkg::MAX_ID_DIGITS)) || (id_val >= VW'(MAX_CPUS));

    // Closing an item: a single id is the range id..id.
    range_lo = first_id_r;
    range_hi = (phase_r == PH_SECOND) ? second_id_r : first_id_r;
    descending = (phase_r == PH_SECOND) && (second_id_r < first_id_r);
    for (int i = 0; i < MAX_CPUS; i++) begin
      range_bits[i] = (IDW'(i) >= range_lo) && (IDW'(i) <= range_hi);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    first_id_nxt = first_id_r;
    second_id_nxt = second_id_r;
    digit_count_nxt = digit_count_r;
    mask_nxt = mask_r;
    err_nxt = err_r;
    len_nxt = len_r;
    end_err = err_r;
    end_mask = mask_r;
    end_status = err_r;

    if (ctl.char_take) begin
      if (len_r < LENW'(MAX_TEXT_LEN)) begin
        len_nxt = len_r + LENW'(1);
      end
      // Once an error is recorded the text is only counted. On a range error the
      // id registers may take a truncated value, which is never read again.
      if (err_r == clbp_pkg::ST_OK) begin
        case (phase_r)
          PH_START, PH_DASH: begin
            if (is_digit) begin
              digit_count_nxt = cnt_inc;
              if (phase_r == PH_START) begin
                first_id_nxt = id_val[IDW-1:0];
                phase_nxt = PH_FIRST;
              end else begin
                second_id_nxt = id_val[IDW-1:0];
                phase_nxt = PH_SECOND;
              end
              if (digit_bad) begin
                err_nxt = clbp_pkg::ST_RANGE;
              end
            end else if (!(is_blank && phase_r == PH_START)) begin
              err_nxt = clbp_pkg::ST_SYNTAX;
            end
          end
          PH_FIRST, PH_SECOND: begin
            if (is_digit) begin
              digit_count_nxt = cnt_inc;
              if (phase_r == PH_FIRST) begin
                first_id_nxt = id_val[IDW-1:0];
              end else begin
                second_id_nxt = id_val[IDW-1:0];
              end
              if (digit_bad) begin
                err_nxt = clbp_pkg::ST_RANGE;
              end
            end else if (phase_r == PH_FIRST && char_byte == clbp_pkg::CH_DASH) begin
              phase_nxt = PH_DASH;
            end else if (descending) begin
              err_nxt = clbp_pkg::ST_SYNTAX;
            end else begin
              mask_nxt = mask_r | range_bits;
              if (is_blank) begin
                phase_nxt = PH_AFTER;
              end else if (char_byte == clbp_pkg::CH_COMMA) begin
                phase_nxt = PH_START;
              end else begin
                err_nxt = clbp_pkg::ST_SYNTAX;
              end
            end
          end
          default: begin
            if (char_byte == clbp_pkg::CH_COMMA) begin
              phase_nxt = PH_START;
            end else if (!is_blank) begin
              err_nxt = clbp_pkg::ST_SYNTAX;
            end
          end
        endcase
      end
    end

    if (ctl.end_take) begin
      // Close whatever item is still open, then report and start afresh.
      if (err_r == clbp_pkg::ST_OK) begin
        if (phase_r == PH_DASH) begin
          end_err = clbp_pkg::ST_SYNTAX;
        end else if (in_id) begin
          if (descending) begin
            end_err = clbp_pkg::ST_SYNTAX;
          end else begin
            end_mask = mask_r | range_bits;
          end
        end
      end
      end_status = (len_r >= LENW'(MAX_TEXT_LEN)) ? clbp_pkg::ST_SYNTAX : end_err;

      phase_nxt = PH_START;
      first_id_nxt = '0;
      second_id_nxt = '0;
      digit_count_nxt = '0;
      mask_nxt = '0;
      err_nxt = clbp_pkg::ST_OK;
      len_nxt = '0;
    end

    result.status = end_status;
    result.mask = (end_status == clbp_pkg::ST_OK) ?
                  clbp_pkg::CPU_MASK_W'(end_mask) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      first_id_r <= '0;
      second_id_r <= '0;
      digit_count_r <= '0;
      mask_r <= '0;
      err_r <= clbp_pkg::ST_OK;
      len_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      first_id_r <= first_id_nxt;
      second_id_r <= second_id_nxt;
      digit_count_r <= digit_count_nxt;
      mask_r <= mask_nxt;
      err_r <= err_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

// ----- hdl/cpu_list_to_bitmap_parser.sv -----
// Top level of the CPU list parser: input register, parser core, result and output registers.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------------
//   in_     | into      | in_valid, in_stall | in_data: char_byte, end_of_text
//   out_    | out of    | out_valid, out_stall | out_data: cpu_mask, set_count, status
//
// One beat is accepted per cycle for as long as the output side keeps up;
// character beats wait for the output only when queued behind a held end beat.
// The result of a text passes through the input register, the parser result
// register, then the output register where the bit count is added.
// in_stall is derived combinationally from out_stall, through the occupancy of the
// three registers, so an end beat waits only when all slots ahead are full and stalled.
// Reset is synchronous and active low; it empties every register slot and
// returns the parser to the start of an empty text.
module cpu_list_to_bitmap_parser #(
  parameter int MAX_CPUS = 64,
  parameter int MAX_TEXT_LEN = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  clbp_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output clbp_pkg::out_beat_t out_data
);

  // Input register.
  logic                    in_valid_r, in_valid_nxt;
  clbp_pkg::in_beat_t      in_beat_r;

  // Parser result register, holding one finished text.
  logic                    done_valid_r, done_valid_nxt;
  clbp_pkg::parse_result_t done_r;

  // Output register.
  logic                    out_valid_r, out_valid_nxt;
  clbp_pkg::out_beat_t     out_data_r;

  logic                    out_free, done_move, done_free, par_take, in_take;
  clbp_pkg::parse_ctl_t    ctl;
  clbp_pkg::parse_result_t par_result;

  // Each slot can advance when the slot ahead of it is empty or emptying.
  // Character beats are consumed by the parser without needing a slot ahead.
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    done_move = done_valid_r && out_free;
    done_free = !done_valid_r || done_move;
    par_take = in_valid_r && (!in_beat_r.end_of_text || done_free);
    in_stall = in_valid_r && !par_take;
    in_take = in_valid && !in_stall;

    ctl.char_take = par_take && !in_beat_r.end_of_text;
    ctl.end_take = par_take && in_beat_r.end_of_text;

    in_valid_nxt = in_take || (in_valid_r && !par_take);
    done_valid_nxt = ctl.end_take || (done_valid_r && !done_move);
    out_valid_nxt = done_move || (out_valid_r && out_stall);
  end

  clbp_parser #(
    .MAX_CPUS(MAX_CPUS),
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_parser (
    .clk(clk),
    .rst_n(rst_n),
    .ctl(ctl),
    .char_byte(in_beat_r.char_byte),
    .result(par_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      done_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      done_valid_r <= done_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load only when their slot takes a new beat.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_beat_r <= in_data;
    end
    if (ctl.end_take) begin
      done_r <= par_result;
    end
    if (done_move) begin
      out_data_r.cpu_mask <= done_r.mask;
      out_data_r.set_count <= clbp_pkg::popcount64(done_r.mask);
      out_data_r.status <= done_r.status;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
